[hw/rtl/notification_rate_limiter_assert.svh]
// ----------------------------------------------------------------------------
// notification_rate_limiter_assert.svh
// Assertion helpers used by the rate limiter top level.
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_RATE_LIMITER_ASSERT_SVH
`define NOTIFICATION_RATE_LIMITER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define NRL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("rate limiter check failed");

// Check that a condition implies another in the following cycle.
`define NRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("rate limiter check failed");

`endif

[hw/rtl/nrl_pkg.sv]
// ----------------------------------------------------------------------------
// nrl_pkg
// Types and constants shared by the notification rate limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nrl_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_INIT       = 2'd0,
        CMD_TIME_CHECK = 2'd1,
        CMD_QUERY      = 2'd2,
        CMD_RESERVE    = 2'd3
    } nrl_command_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_DAY_QUIET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENROLLED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GENTLE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_DEADLINE = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MINUTE_W   = 11;

    // Time constants, signed: day and gap 33 bits, PAUSE_FOREVER 32 bits
    localparam logic signed [32:0] DAY_SECONDS   = 33'sd86400;
    localparam logic signed [32:0] GAP_SECONDS   = 33'sd5400;
    localparam logic signed [31:0] PAUSE_FOREVER = -32'sd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted beat
        logic exec;   // apply the command, set up query checks
        logic scan;   // check one grant slot
    } nrl_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        nrl_command_t cmd;
        logic         answer;
    } nrl_status_t;

endpackage

`default_nettype wire

[hw/rtl/notification_rate_limiter.sv]
// Sequence: an input beat is accepted in ST_IDLE and applied in ST_EXEC; a query
//   then checks one grant slot a cycle in ST_SCAN; ST_OUT loads the result beat.
// Flow: one item at a time; ST_OUT waits while a previous result is untaken, and
//   the next item is accepted while the previous result waits on m_tready.
// Reset: aresetn synchronous, active low; clears the limiter state, the grant
//   slots and all configuration registers.
// ----------------------------------------------------------------------------
// notification_rate_limiter
// Admission limiter for notifications with a sequencing controller and a
// datapath holding the grant stamps, hold deadline and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

`include "notification_rate_limiter_assert.svh"

module notification_rate_limiter
    import nrl_pkg::*;
#(
    parameter int unsigned SLOTS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] now_seconds, [32] time_reliable, [43:33] minute_of_day,
    // [44] host_quiet, [47:45] zero
    input  wire logic [47:0]           s_tdata,
    // [1:0] command
    input  wire logic [1:0]            s_tuser,
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] answer, [7:1] zero
    output logic [7:0]                 m_tdata
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    nrl_ctrl_t        ctrl;
    nrl_status_t      status;
    logic [IDX_W-1:0] slot_idx;
    logic             m_answer;

    assign m_tdata = {7'b0, m_answer};

    nrl_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_answer (m_answer),
        .ctrl     (ctrl),
        .slot_idx (slot_idx),
        .status   (status)
    );

    nrl_datapath #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_command       (s_tuser),
        .in_now_seconds   (s_tdata[31:0]),
        .in_time_reliable (s_tdata[32]),
        .in_minute_of_day (s_tdata[43:33]),
        .in_host_quiet    (s_tdata[44]),
        .ctrl             (ctrl),
        .slot_idx         (slot_idx),
        .status           (status)
    );

    // One item in flight: no new beat right after an accept
    `NRL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // Slot scans happen only for queries
    `NRL_ASSERT_SAME(a_scan_query_only, ctrl.scan, status.cmd == CMD_QUERY)
    // Init and reserve always answer zero
    `NRL_ASSERT_NEXT(a_zero_answer,
        ctrl.exec && (status.cmd == CMD_INIT || status.cmd == CMD_RESERVE),
        !status.answer)

endmodule

`default_nettype wire

[hw/rtl/nrl_datapath.sv]
// ----------------------------------------------------------------------------
// nrl_datapath
// Item registers, limiter state, configuration registers and the admission
// checks, one grant slot per scan step.
// ----------------------------------------------------------------------------
`default_nettype none

module nrl_datapath
    import nrl_pkg::*;
#(
    parameter int unsigned SLOTS = 4,
    parameter int unsigned IDX_W = 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [1:0]            in_command,
    input  wire logic [31:0]           in_now_seconds,
    input  wire logic                  in_time_reliable,
    input  wire logic [MINUTE_W-1:0]   in_minute_of_day,
    input  wire logic                  in_host_quiet,
    input  wire nrl_ctrl_t             ctrl,
    input  wire logic [IDX_W-1:0]      slot_idx,
    output nrl_status_t                status
);

    localparam int unsigned CNT_W = $clog2(SLOTS + 1);

    // Configuration registers
    logic                       all_day_quiet_reg;
    logic [MINUTE_W-1:0]        quiet_start_reg;
    logic [MINUTE_W-1:0]        quiet_end_reg;
    logic                       enrolled_reg;
    logic                       gentle_mode_reg;
    logic signed [31:0]         pause_deadline_reg;

    // Captured item
    nrl_command_t               cmd_reg;
    logic signed [31:0]         now_reg;
    logic                       reliable_reg;
    logic [MINUTE_W-1:0]        minute_reg;
    logic                       sys_quiet_reg;

    // Limiter state
    logic                       initialised_reg, initialised_next;
    logic signed [32:0]         hold_reg, hold_next;
    logic signed [31:0]         last_trusted_reg, last_trusted_next;
    logic signed [31:0]         stamps_reg [SLOTS];
    logic signed [31:0]         stamps_next [SLOTS];

    // Query accumulation and plain answer
    logic                       ok_reg, ok_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       answer_reg, answer_next;

    logic signed [32:0]         now_ext;
    logic signed [32:0]         day_deadline;
    logic signed [31:0]         last_eff;
    logic                       went_back;
    logic                       in_quiet;
    logic                       base_ok;
    logic signed [31:0]         slot_val;
    logic signed [32:0]         slot_ext;
    logic signed [32:0]         slot_age;
    logic                       slot_used;

    assign now_ext      = {now_reg[31], now_reg};
    assign day_deadline = now_ext + DAY_SECONDS;

    // Until the first init or time check, the time check treats now as the last trusted time
    assign last_eff  = initialised_reg ? last_trusted_reg : now_reg;
    assign went_back = now_reg < last_eff;

    // Quiet window, wrapping past midnight when start is above end
    always_comb begin
        if (all_day_quiet_reg) begin
            in_quiet = 1'b1;
        end else if (quiet_start_reg == quiet_end_reg) begin
            in_quiet = 1'b0;
        end else if (quiet_start_reg < quiet_end_reg) begin
            in_quiet = (minute_reg >= quiet_start_reg) && (minute_reg < quiet_end_reg);
        end else begin
            in_quiet = (minute_reg >= quiet_start_reg) || (minute_reg < quiet_end_reg);
        end
    end

    // Rules that do not depend on the grant slots
    assign base_ok = enrolled_reg && gentle_mode_reg && !sys_quiet_reg && !in_quiet
                     && (pause_deadline_reg != PAUSE_FOREVER)
                     && !(pause_deadline_reg > now_reg)
                     && !(now_ext < hold_reg);

    // One grant slot under test
    assign slot_val  = stamps_reg[slot_idx];
    assign slot_ext  = {slot_val[31], slot_val};
    assign slot_age  = now_ext - slot_ext;
    assign slot_used = (slot_val != 32'sd0);

    // Next-state logic
    always_comb begin
        initialised_next  = initialised_reg;
        hold_next         = hold_reg;
        last_trusted_next = last_trusted_reg;
        for (int i = 0; i < SLOTS; i++) begin
            stamps_next[i] = stamps_reg[i];
        end
        ok_next     = ok_reg;
        count_next  = count_reg;
        answer_next = answer_reg;

        if (ctrl.exec) begin
            answer_next = 1'b0;
            ok_next     = base_ok;
            count_next  = '0;
            case (cmd_reg)
                CMD_INIT: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        stamps_next[i] = '0;
                    end
                    hold_next         = day_deadline;
                    last_trusted_next = now_reg;
                    initialised_next  = 1'b1;
                end
                CMD_TIME_CHECK: begin
                    if (!initialised_reg) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            stamps_next[i] = '0;
                        end
                    end
                    if (!initialised_reg || !reliable_reg || went_back) begin
                        hold_next = day_deadline;
                    end
                    answer_next       = reliable_reg && !went_back;
                    last_trusted_next = now_reg;
                    initialised_next  = 1'b1;
                end
                CMD_RESERVE: begin
                    // shift toward slot zero, drop the oldest
                    for (int i = 0; i + 1 < SLOTS; i++) begin
                        stamps_next[i] = stamps_reg[i + 1];
                    end
                    stamps_next[SLOTS-1] = now_reg;
                end
                default: begin
                end
            endcase
        end

        // Scan one slot: future stamp, recent gap, daily count
        if (ctrl.scan) begin
            if (slot_ext > now_ext) begin
                ok_next = 1'b0;
            end
            if (slot_used && (slot_age < GAP_SECONDS)) begin
                ok_next = 1'b0;
            end
            if (slot_used && (slot_age < DAY_SECONDS)) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Result of the current command
    always_comb begin
        status.cmd = cmd_reg;
        if (cmd_reg == CMD_QUERY) begin
            status.answer = ok_reg && (count_reg < CNT_W'(SLOTS));
        end else begin
            status.answer = answer_reg;
        end
    end

    // Capture the accepted beat and register the query accumulation and answer
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg       <= nrl_command_t'(in_command);
            now_reg       <= in_now_seconds;
            reliable_reg  <= in_time_reliable;
            minute_reg    <= in_minute_of_day;
            sys_quiet_reg <= in_host_quiet;
        end
        ok_reg     <= ok_next;
        count_reg  <= count_next;
        answer_reg <= answer_next;
    end

    // Hold limiter state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initialised_reg    <= 1'b0;
            hold_reg           <= '0;
            last_trusted_reg   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                stamps_reg[i] <= '0;
            end
            all_day_quiet_reg  <= 1'b0;
            quiet_start_reg    <= '0;
            quiet_end_reg      <= '0;
            enrolled_reg       <= 1'b0;
            gentle_mode_reg    <= 1'b0;
            pause_deadline_reg <= '0;
        end else begin
            initialised_reg  <= initialised_next;
            hold_reg         <= hold_next;
            last_trusted_reg <= last_trusted_next;
            for (int i = 0; i < SLOTS; i++) begin
                stamps_reg[i] <= stamps_next[i];
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ALL_DAY_QUIET:  all_day_quiet_reg  <= cfg_wdata[0];
                    REG_QUIET_START:    quiet_start_reg    <= cfg_wdata[MINUTE_W-1:0];
                    REG_QUIET_END:      quiet_end_reg      <= cfg_wdata[MINUTE_W-1:0];
                    REG_ENROLLED:       enrolled_reg       <= cfg_wdata[0];
                    REG_GENTLE_MODE:    gentle_mode_reg    <= cfg_wdata[0];
                    REG_PAUSE_DEADLINE: pause_deadline_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/nrl_ctrl.sv]
// ----------------------------------------------------------------------------
// nrl_ctrl
// Sequencer for one item: accept, execute, scan the grant slots on a query,
// then load the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrl_ctrl
    import nrl_pkg::*;
#(
    parameter int unsigned SLOTS = 4,
    parameter int unsigned IDX_W = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic                  m_answer,
    output nrl_ctrl_t             ctrl,
    output logic [IDX_W-1:0]      slot_idx,
    input  wire nrl_status_t      status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             answer_reg, answer_next;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_answer = answer_reg;
    assign slot_idx = idx_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Commands to the datapath
    always_comb begin
        ctrl.load = (state_reg == ST_IDLE) && s_tvalid;
        ctrl.exec = (state_reg == ST_EXEC);
        ctrl.scan = (state_reg == ST_SCAN);
    end

    // Advance the sequence
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        answer_next   = answer_reg;

        // drop the beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                idx_next = '0;
                if (status.cmd == CMD_QUERY) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN: begin
                if (idx_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    answer_next   = status.answer;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            answer_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            answer_reg   <= answer_next;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_notification_rate_limiter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_notification_rate_limiter
// Self-checking bench for the notification admission limiter. A queue of
// commands feeds a clocked stream driver. Each accepted beat updates a local
// model of the slots, hold deadline and trusted time, and queues the answer
// it expects. A clocked monitor compares every result beat with the oldest
// expected answer. A short directed pass covers the rule edges, then random
// phases mix well-formed timelines with noise beats under random settings.
// Both sides apply random stalls, and there are two long receiver hold-offs.
// ----------------------------------------------------------------------------

module tb_notification_rate_limiter
    import nrl_pkg::*;
();

    localparam int unsigned SLOTS      = 4;
    localparam int unsigned LATENCY    = 3 + SLOTS;
    localparam int unsigned HOLD_OFF   = 400;
    localparam int unsigned CHUNKS     = 21;
    localparam int unsigned CHUNK_LEN  = 50;

    typedef struct {
        nrl_command_t       cmd;
        logic signed [31:0] now;
        logic               reliable;
        logic [10:0]        minute;
        logic               sys_quiet;
    } notice_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;

    notification_rate_limiter #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the configuration registers
    logic               cfg_all_day;
    logic [10:0]        cfg_quiet_start;
    logic [10:0]        cfg_quiet_end;
    logic               cfg_enrolled;
    logic               cfg_gentle;
    logic signed [31:0] cfg_pause_dl;

    // Shadow copy of the limiter state
    logic               lim_ready;
    logic signed [32:0] lim_hold_dl;
    logic signed [31:0] lim_last_trusted;
    logic signed [31:0] lim_stamps [SLOTS];

    notice_t            notice_q [$];
    logic               expected_answers [$];
    int unsigned        mismatch_count = 0;

    // Stimulus controls shared with the driver and monitor
    bit                 send_calm = 1'b0;
    bit                 recv_calm = 1'b0;
    int unsigned        hold_req  = 0;
    logic signed [31:0] scene_now = 32'sd1000000000;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Clear the slots and restart the one-day hold
    function automatic void restart_limiter(input logic signed [31:0] now);
        for (int i = 0; i < SLOTS; i++) lim_stamps[i] = '0;
        lim_hold_dl      = now + DAY_SECONDS;
        lim_last_trusted = now;
        lim_ready        = 1'b1;
    endfunction

    // Apply one command to the shadow state and return its answer
    function automatic logic apply_notice(input notice_t n);
        logic               answer;
        logic               quiet;
        logic signed [33:0] age;
        int unsigned        recent;
        answer = 1'b0;
        case (n.cmd)
            CMD_INIT: begin
                restart_limiter(n.now);
            end
            CMD_TIME_CHECK: begin
                if (!lim_ready) restart_limiter(n.now);
                if (!n.reliable || n.now < lim_last_trusted) begin
                    lim_hold_dl = n.now + DAY_SECONDS;
                end else begin
                    answer = 1'b1;
                end
                lim_last_trusted = n.now;
            end
            CMD_QUERY: begin
                // quiet window, possibly wrapping past midnight
                if (cfg_all_day) begin
                    quiet = 1'b1;
                end else if (cfg_quiet_start == cfg_quiet_end) begin
                    quiet = 1'b0;
                end else if (cfg_quiet_start < cfg_quiet_end) begin
                    quiet = n.minute >= cfg_quiet_start && n.minute < cfg_quiet_end;
                end else begin
                    quiet = n.minute >= cfg_quiet_start || n.minute < cfg_quiet_end;
                end
                answer = cfg_enrolled && cfg_gentle && !n.sys_quiet && !quiet
                         && cfg_pause_dl != PAUSE_FOREVER && cfg_pause_dl <= n.now
                         && !(n.now < lim_hold_dl);
                // slot rules: nothing in the future, spacing, daily budget
                recent = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    age = n.now - lim_stamps[i];
                    if (lim_stamps[i] > n.now) answer = 1'b0;
                    if (lim_stamps[i] != 0 && age < DAY_SECONDS) recent++;
                    if (lim_stamps[i] != 0 && age < GAP_SECONDS) answer = 1'b0;
                end
                if (recent >= SLOTS) answer = 1'b0;
            end
            default: begin
                for (int i = 0; i + 1 < SLOTS; i++) lim_stamps[i] = lim_stamps[i + 1];
                lim_stamps[SLOTS - 1] = n.now;
            end
        endcase
        return answer;
    endfunction

    // Build the next random command: a plausible timeline or a noise beat
    function automatic notice_t next_notice(input bit noisy);
        notice_t     n;
        int unsigned pick;
        if (noisy) begin
            n.cmd       = nrl_command_t'($urandom_range(0, 3));
            n.now       = $urandom;
            n.reliable  = 1'($urandom_range(0, 1));
            n.minute    = 11'($urandom_range(0, 2047));
            n.sys_quiet = 1'($urandom_range(0, 1));
            return n;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            scene_now += $urandom_range(0, 120);
        end else if (pick < 60) begin
            scene_now += $urandom_range(5000, 6000);
        end else if (pick < 92) begin
            scene_now += $urandom_range(20000, 90000);
        end else begin
            scene_now -= $urandom_range(1, 3000);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            n.cmd = CMD_INIT;
        end else if (pick < 30) begin
            n.cmd = CMD_TIME_CHECK;
        end else if (pick < 75) begin
            n.cmd = CMD_QUERY;
        end else begin
            n.cmd = CMD_RESERVE;
        end
        n.now       = scene_now;
        n.reliable  = ($urandom_range(0, 9) != 0);
        n.minute    = 11'($urandom_range(0, 1439));
        n.sys_quiet = ($urandom_range(0, 9) == 0);
        return n;
    endfunction

    task automatic queue_notice(input nrl_command_t cmd, input logic signed [31:0] now,
                                input logic reliable, input logic [10:0] minute,
                                input logic sys_quiet);
        notice_t n;
        n.cmd       = cmd;
        n.now       = now;
        n.reliable  = reliable;
        n.minute    = minute;
        n.sys_quiet = sys_quiet;
        notice_q.push_back(n);
    endtask

    // Write one register while the block is idle and mirror it
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ALL_DAY_QUIET:  cfg_all_day     = value[0];
            REG_QUIET_START:    cfg_quiet_start = value[10:0];
            REG_QUIET_END:      cfg_quiet_end   = value[10:0];
            REG_ENROLLED:       cfg_enrolled    = value[0];
            REG_GENTLE_MODE:    cfg_gentle      = value[0];
            REG_PAUSE_DEADLINE: cfg_pause_dl    = value;
            default: ;
        endcase
    endtask

    // Wait until every queued beat is answered, then let the block settle
    task automatic settle();
        while (notice_q.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
    endtask

    // Stream driver: predict on acceptance, then offer the next beat
    notice_t     offered;
    int unsigned send_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(apply_notice(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (notice_q.size() != 0) begin
                    offered = notice_q.pop_front();
                    s_tuser  <= offered.cmd;
                    s_tdata  <= {3'b000, offered.sys_quiet, offered.minute,
                                 offered.reliable, offered.now};
                    s_tvalid <= 1'b1;
                    send_wait = send_calm ? 0 : $urandom_range(0, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat, then pick the next stall
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    int unsigned hold_seen = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, answer %0b",
                                              m_tdata[0]));
                end else if (m_tdata[0] !== expected_answers[0]) begin
                    report_mismatch($sformatf("answer %0b, expected %0b",
                                              m_tdata[0], expected_answers[0]));
                    void'(expected_answers.pop_front());
                end else begin
                    void'(expected_answers.pop_front());
                end
                recv_wait = recv_calm ? 0 : $urandom_range(0, 13);
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        cfg_all_day      = 1'b0;
        cfg_quiet_start  = '0;
        cfg_quiet_end    = '0;
        cfg_enrolled     = 1'b0;
        cfg_gentle       = 1'b0;
        cfg_pause_dl     = '0;
        lim_ready        = 1'b0;
        lim_hold_dl      = '0;
        lim_last_trusted = '0;
        for (int i = 0; i < SLOTS; i++) lim_stamps[i] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings: not enrolled, so the query is refused
        queue_notice(CMD_QUERY, 32'sd0, 1'b0, 11'd0, 1'b0);
        settle();
        write_setting(REG_ENROLLED, 32'd1);
        write_setting(REG_GENTLE_MODE, 32'd1);

        // Uninitialised state, then time checks, spacing and daily budget
        queue_notice(CMD_QUERY, 32'sd0, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, -32'sd1, 1'b1, 11'd0, 1'b0);
        queue_notice(CMD_RESERVE, 32'sd100, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_TIME_CHECK, 32'sd1000, 1'b1, 11'd0, 1'b0);
        queue_notice(CMD_TIME_CHECK, 32'sd500, 1'b1, 11'd0, 1'b0);
        queue_notice(CMD_TIME_CHECK, 32'sd600, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sd87000, 1'b0, 11'd1439, 1'b0);
        queue_notice(CMD_RESERVE, 32'sd87000, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sd92399, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sd92400, 1'b0, 11'd0, 1'b1);
        queue_notice(CMD_QUERY, 32'sd92400, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_RESERVE, 32'sd92400, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_RESERVE, 32'sd97800, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_RESERVE, 32'sd103200, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sd108600, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sd173400, 1'b0, 11'd0, 1'b0);
        // Time extremes: hold past the top of the 32-bit range, then the bottom
        queue_notice(CMD_INIT, 32'sh7fffffff, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_QUERY, 32'sh7fffffff, 1'b1, 11'd2047, 1'b1);
        queue_notice(CMD_INIT, 32'sh80000000, 1'b0, 11'd0, 1'b0);
        queue_notice(CMD_TIME_CHECK, 32'sh80000000, 1'b1, 11'd0, 1'b0);
        settle();

        // Quiet window wrapping past midnight
        write_setting(REG_QUIET_START, 32'd1380);
        write_setting(REG_QUIET_END, 32'd360);
        queue_notice(CMD_QUERY, 32'sd1000000, 1'b0, 11'd1400, 1'b0);
        queue_notice(CMD_QUERY, 32'sd1000000, 1'b0, 11'd720, 1'b0);
        settle();
        // Window from minute 0 to 1439, end exclusive
        write_setting(REG_QUIET_START, 32'd0);
        write_setting(REG_QUIET_END, 32'd1439);
        write_setting(REG_ALL_DAY_QUIET, 32'd0);
        queue_notice(CMD_QUERY, 32'sd1000000, 1'b0, 11'd1439, 1'b0);
        settle();
        write_setting(REG_ALL_DAY_QUIET, 32'd1);
        queue_notice(CMD_QUERY, 32'sd1000000, 1'b0, 11'd1439, 1'b0);
        settle();
        // Paused forever, then paused until the last second
        write_setting(REG_ALL_DAY_QUIET, 32'd0);
        write_setting(REG_PAUSE_DEADLINE, 32'hffffffff);
        queue_notice(CMD_QUERY, 32'sd1000000, 1'b0, 11'd1439, 1'b0);
        settle();
        write_setting(REG_PAUSE_DEADLINE, 32'h7fffffff);
        queue_notice(CMD_QUERY, 32'sh7fffffff, 1'b0, 11'd1439, 1'b0);
        settle();

        // Random phases, each under fresh settings
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            write_setting(REG_ALL_DAY_QUIET, CFG_DATA_W'($urandom_range(0, 9) == 0));
            write_setting(REG_QUIET_START, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 2047) : $urandom_range(0, 1439));
            write_setting(REG_QUIET_END, ($urandom_range(0, 4) == 0) ?
                          CFG_DATA_W'(cfg_quiet_start) : $urandom_range(0, 1439));
            write_setting(REG_ENROLLED, CFG_DATA_W'($urandom_range(0, 9) != 0));
            write_setting(REG_GENTLE_MODE, CFG_DATA_W'($urandom_range(0, 9) != 0));
            case ($urandom_range(0, 9))
                0:       write_setting(REG_PAUSE_DEADLINE, PAUSE_FOREVER);
                1:       write_setting(REG_PAUSE_DEADLINE, $urandom);
                2:       write_setting(REG_PAUSE_DEADLINE, scene_now + $urandom_range(0, 200000));
                default: write_setting(REG_PAUSE_DEADLINE, 32'd0);
            endcase
            if ($urandom_range(0, 9) == 0) scene_now = $urandom;
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < CHUNK_LEN; k++) begin
                notice_q.push_back(next_notice($urandom_range(0, 99) < 15));
            end
            // Back-pressure: the receiver holds off while the sender keeps offering
            if (chunk == 5 || chunk == 14) begin
                send_calm = 1'b1;
                hold_req++;
            end
            // Sender pauses here until every expected answer has come back
            settle();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
